@@ hw/rtl/kot_pkg.sv @@
// ----------------------------------------------------------------------------
// kot_pkg
// Shared types and constants for the keyed one-shot timer table.
// ----------------------------------------------------------------------------
package kot_pkg;

  localparam int unsigned KeyW  = 16;
  localparam int unsigned TimeW = 32;

  // Depth of the request queue between front and back
  localparam int unsigned ReqQDepth = 2;
  localparam int unsigned ReqQPtrW  = (ReqQDepth > 1) ? $clog2(ReqQDepth) : 1;
  localparam int unsigned ReqQCntW  = $clog2(ReqQDepth + 1);

  // Input item as seen on the push side
  typedef struct packed {
    logic [KeyW-1:0]  timer_key;
    logic [TimeW-1:0] duration_ms;
    logic [TimeW-1:0] now_ms;
  } in_item_t;

  // Result item as seen on the pop side
  typedef struct packed {
    logic expired;
    logic newly_armed;
    logic rejected_full;
  } out_item_t;

  // Request with its computed deadline, handed from front to back
  typedef struct packed {
    logic [KeyW-1:0]  timer_key;
    logic [TimeW-1:0] deadline_ms;
    logic [TimeW-1:0] now_ms;
  } req_t;

  // One stored timer entry
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] deadline;
  } entry_t;

  // Handshake between request queue and back end
  typedef struct packed {
    logic valid;
    req_t req;
  } req_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } back_state_e;

endpackage

@@ hw/rtl/kot_front.sv @@
// ----------------------------------------------------------------------------
// kot_front
// Input stage: accept an item, compute its deadline and hold the request
// until the request queue takes it.
// ----------------------------------------------------------------------------
module kot_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  kot_pkg::in_item_t item_i,
  output logic              req_vld_o,
  output kot_pkg::req_t     req_o,
  input  logic              req_rdy_i
);

  logic          vld_q, vld_d;
  kot_pkg::req_t req_q;
  logic          accept;

  assign full      = vld_q && !req_rdy_i;
  assign accept    = push && !full;
  assign req_vld_o = vld_q;
  assign req_o     = req_q;

  // Advance the holding register
  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (req_rdy_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Capture key and deadline, wrapping modulo 2^32
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.timer_key   <= item_i.timer_key;
      req_q.deadline_ms <= item_i.now_ms + item_i.duration_ms;
      req_q.now_ms      <= item_i.now_ms;
    end
  end

endmodule

@@ hw/rtl/kot_req_fifo.sv @@
// ----------------------------------------------------------------------------
// kot_req_fifo
// Short request queue that decouples the front stage from the scan engine.
// ----------------------------------------------------------------------------
module kot_req_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_vld_i,
  input  kot_pkg::req_t       wr_req_i,
  output logic                wr_rdy_o,
  output kot_pkg::req_head_t  head_o,
  input  logic                rd_pop_i
);

  kot_pkg::req_t                   slot_q [kot_pkg::ReqQDepth];
  logic [kot_pkg::ReqQPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [kot_pkg::ReqQCntW-1:0]    cnt_q;
  logic                            wr_en, rd_en;

  assign wr_rdy_o    = (cnt_q != kot_pkg::ReqQCntW'(kot_pkg::ReqQDepth));
  assign wr_en       = wr_vld_i && wr_rdy_o;
  assign rd_en       = rd_pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.req   = slot_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == kot_pkg::ReqQPtrW'(kot_pkg::ReqQDepth - 1)) ? '0
                                                                             : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == kot_pkg::ReqQPtrW'(kot_pkg::ReqQDepth - 1)) ? '0
                                                                             : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store incoming requests
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= wr_req_i;
    end
  end

endmodule

@@ hw/rtl/kot_back.sv @@
// ----------------------------------------------------------------------------
// kot_back
// Scan engine: sweep the entry memory for the polled key and the first free
// entry, then expire, arm, reject or keep an undue hit; post the result item.
// ----------------------------------------------------------------------------
module kot_back #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kot_pkg::req_head_t head_i,
  output logic               req_pop_o,
  output logic               empty,
  input  logic               pop,
  output kot_pkg::out_item_t result_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  kot_pkg::back_state_e state_q, state_d;

  kot_pkg::entry_t    mem_q [ENTRIES];
  kot_pkg::entry_t    rd_q;
  logic [ENTRIES-1:0] valid_q;
  logic [CntW-1:0]    cnt_q;

  logic [IdxW-1:0]    idx_q, pend_idx_q, free_idx_q, hit_idx_q;
  logic               pend_q, pend_vld_q;
  logic               free_found_q, hit_found_q, hit_due_q;

  kot_pkg::out_item_t res_q, res_d;
  logic               res_vld_q;
  logic               commit, is_full;

  assign empty    = !res_vld_q;
  assign result_o = res_q;
  assign is_full  = (cnt_q == CntW'(ENTRIES));

  // Classify the finished scan
  always_comb begin
    res_d.expired       = hit_found_q && hit_due_q;
    res_d.newly_armed   = !hit_found_q && !is_full;
    res_d.rejected_full = !hit_found_q && is_full;
  end

  // Sequence scan, drain and commit
  always_comb begin
    state_d   = state_q;
    commit    = 1'b0;
    req_pop_o = 1'b0;
    unique case (state_q)
      kot_pkg::ST_IDLE: begin
        if (head_i.valid) state_d = kot_pkg::ST_SCAN;
      end
      kot_pkg::ST_SCAN: begin
        if (idx_q == LastIdx) state_d = kot_pkg::ST_DRAIN;
      end
      kot_pkg::ST_DRAIN: begin
        state_d = kot_pkg::ST_COMMIT;
      end
      kot_pkg::ST_COMMIT: begin
        if (!res_vld_q || pop) begin
          commit    = 1'b1;
          req_pop_o = 1'b1;
          state_d   = kot_pkg::ST_IDLE;
        end
      end
      default: state_d = kot_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kot_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Track scan position, first free entry and key match
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      pend_q       <= 1'b0;
      free_found_q <= 1'b0;
      hit_found_q  <= 1'b0;
    end else begin
      pend_q <= (state_q == kot_pkg::ST_SCAN);
      if (state_q == kot_pkg::ST_IDLE) begin
        idx_q        <= '0;
        free_found_q <= 1'b0;
        hit_found_q  <= 1'b0;
      end else begin
        if (state_q == kot_pkg::ST_SCAN) begin
          if (idx_q != LastIdx) idx_q <= idx_q + 1'b1;
          if (!valid_q[idx_q] && !free_found_q) free_found_q <= 1'b1;
        end
        if (pend_q && pend_vld_q && !hit_found_q &&
            rd_q.key == head_i.req.timer_key) begin
          hit_found_q <= 1'b1;
        end
      end
    end
  end

  // Hold payload alongside the scan flags
  always_ff @(posedge clk_i) begin
    pend_idx_q <= idx_q;
    pend_vld_q <= valid_q[idx_q];
    if (state_q == kot_pkg::ST_SCAN && !valid_q[idx_q] && !free_found_q) begin
      free_idx_q <= idx_q;
    end
    if (pend_q && pend_vld_q && !hit_found_q && rd_q.key == head_i.req.timer_key) begin
      hit_idx_q <= pend_idx_q;
      hit_due_q <= (rd_q.deadline <= head_i.req.now_ms);
    end
  end

  // Entry memory: a write on commit and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (commit && res_d.newly_armed) begin
      mem_q[free_idx_q] <= '{key: head_i.req.timer_key, deadline: head_i.req.deadline_ms};
    end
    rd_q <= mem_q[idx_q];
  end

  // Update valid bits, occupancy and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (commit) begin
        if (res_d.expired) begin
          valid_q[hit_idx_q] <= 1'b0;
          cnt_q              <= cnt_q - 1'b1;
        end else if (res_d.newly_armed) begin
          valid_q[free_idx_q] <= 1'b1;
          cnt_q               <= cnt_q + 1'b1;
        end
        res_vld_q <= 1'b1;
      end else if (pop) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_q <= res_d;
    end
  end

endmodule

@@ hw/rtl/keyed_oneshot_timer_table.sv @@
// Path: front holding register, request queue, then the back end's idle,
//   scan, drain and commit states into the result register. The back end
//   scans one item at a time via the single read port, one entry per cycle.
// Front stage and two-deep request queue hold up to three items in all.
// Reset: asynchronous, active low; clears all valid bits, occupancy, queues.
// ----------------------------------------------------------------------------
// keyed_oneshot_timer_table
// Table of one-shot timers named by key: poll, arm, expire or reject.
// ----------------------------------------------------------------------------
module keyed_oneshot_timer_table #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  kot_pkg::in_item_t  item_i,
  output logic               empty,
  input  logic               pop,
  output kot_pkg::out_item_t result_o
);

  logic               front_vld, fifo_rdy, req_pop;
  kot_pkg::req_t      front_req;
  kot_pkg::req_head_t head;

  // Accept and compute the deadline
  kot_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .item_i    (item_i),
    .req_vld_o (front_vld),
    .req_o     (front_req),
    .req_rdy_i (fifo_rdy)
  );

  // Decouple front from back
  kot_req_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_vld_i (front_vld),
    .wr_req_i (front_req),
    .wr_rdy_o (fifo_rdy),
    .head_o   (head),
    .rd_pop_i (req_pop)
  );

  // Scan and update
  kot_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .req_pop_o (req_pop),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

endmodule

@@ hw/rtl/kot_checker.sv @@
// ----------------------------------------------------------------------------
// kot_checker
// Port-level checks for the keyed one-shot timer table.
// ----------------------------------------------------------------------------
module kot_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input kot_pkg::out_item_t result_o
);

  logic [3:0] outst_q;

  // Count items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_q + 4'((push && !full) ? 1 : 0) - 4'((pop && !empty) ? 1 : 0);
    end
  end

  // Hold a waiting result until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result changed while waiting");

  // Report exactly one outcome or none
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> $onehot0({result_o.expired, result_o.newly_armed, result_o.rejected_full}))
    else $error("more than one outcome flagged");

  // Never deliver a result without an item behind it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (outst_q != 4'd0))
    else $error("result without accepted item");

  // Bound the items in flight by the buffering
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= 4'd4)
    else $error("too many items in flight");

  // A fresh item never yields a result in the next cycle
  a_min_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && outst_q == 4'd0) |=> empty)
    else $error("result appeared too early");

endmodule

bind keyed_oneshot_timer_table kot_checker u_kot_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
